>>> hw/rtl/hcpp_pkg.sv
// ----------------------------------------------------------------------------
// hcpp_pkg
// Shared types and constants of the circular histogram peak picker.
// ----------------------------------------------------------------------------
package hcpp_pkg;

   localparam int COUNT_W    = 16;
   localparam int SAMPLE_W   = 16;
   localparam int SCALE_W    = 24;
   localparam int WIDTH_W    = 16;
   localparam int LIMIT_W    = 3;
   localparam int BIN_OUT_W  = 8;
   localparam int POS_W      = 32;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = DIFF_W + SCALE_W + 1;
   localparam int FRAC_W     = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [SAMPLE_W-1:0] MIN_VALUE_RST  = 16'hCDBC;  // -12868
   localparam logic [SCALE_W-1:0]  BIN_SCALE_RST  = 24'd10680707;
   localparam logic [WIDTH_W-1:0]  BIN_WIDTH_RST  = 16'd100;
   localparam logic [LIMIT_W-1:0]  PEAK_LIMIT_RST = 3'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_VALUE  = 2'd0,
      CSR_BIN_SCALE  = 2'd1,
      CSR_BIN_WIDTH  = 2'd2,
      CSR_PEAK_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_ACCUM  = 1'b0,
      MODE_FINISH = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_MUL,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic acc_mul;
      logic acc_rd;
      logic acc_wr;
      logic clr_init;
      logic clr_wr;
      logic scan_init;
      logic scan_rd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_last;
      logic pipe_busy;
      logic emit_more;
   } status_type;

endpackage

>>> hw/rtl/hcpp_ctrl.sv
// ----------------------------------------------------------------------------
// hcpp_ctrl
// Sequencer: clear sweep, accumulate read-modify-write, scan, drain, emit.
// ----------------------------------------------------------------------------
module hcpp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_mode,
   output logic                busy,
   output hcpp_pkg::cmd_type    cmd,
   input  hcpp_pkg::status_type status
);

   hcpp_pkg::state_type state_ff;
   hcpp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcpp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         hcpp_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = hcpp_pkg::ST_IDLE;
            end
         end
         hcpp_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               if (req_mode == hcpp_pkg::MODE_FINISH) begin
                  cmd.scan_init = 1'b1;
                  state_in      = hcpp_pkg::ST_SCAN;
               end else begin
                  state_in = hcpp_pkg::ST_ACC_MUL;
               end
            end
         end
         hcpp_pkg::ST_ACC_MUL: begin
            cmd.acc_mul = 1'b1;
            state_in    = hcpp_pkg::ST_ACC_RD;
         end
         hcpp_pkg::ST_ACC_RD: begin
            cmd.acc_rd = 1'b1;
            state_in   = hcpp_pkg::ST_ACC_WR;
         end
         hcpp_pkg::ST_ACC_WR: begin
            cmd.acc_wr = 1'b1;
            state_in   = hcpp_pkg::ST_IDLE;
         end
         hcpp_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = hcpp_pkg::ST_DRAIN;
            end
         end
         hcpp_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = hcpp_pkg::ST_EMIT;
            end
         end
         hcpp_pkg::ST_EMIT: begin
            if (status.emit_more) begin
               cmd.emit = 1'b1;
            end else begin
               cmd.clr_init = 1'b1;
               state_in     = hcpp_pkg::ST_CLEAR;
            end
         end
         default: begin
            state_in = hcpp_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

>>> hw/rtl/hcpp_datapath.sv
// ----------------------------------------------------------------------------
// hcpp_datapath
// Config registers, bin memory, binning arithmetic, sliding suppression
// window, ranked peak list and result registers.
// ----------------------------------------------------------------------------
module hcpp_datapath #(
   parameter int NUM_BINS      = 256,
   parameter int WINDOW_BEFORE = 3,
   parameter int MAX_PEAKS     = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hcpp_pkg::cmd_type                      cmd,
   output hcpp_pkg::status_type                   status,
   input  logic signed [hcpp_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   csr_we,
   input  logic [hcpp_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [hcpp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                   rsp_valid,
   output logic [hcpp_pkg::BIN_OUT_W-1:0]         rsp_bin_index,
   output logic [hcpp_pkg::COUNT_W-1:0]           rsp_hit_count,
   output logic signed [hcpp_pkg::POS_W-1:0]      rsp_peak_position,
   output logic                                   rsp_last
);

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int WIN    = 2 * WINDOW_BEFORE;
   localparam int FILL_W = $clog2(WIN + 1);
   localparam int READS  = NUM_BINS + WIN - 1;
   localparam int RD_W   = $clog2(READS);
   localparam int START  = (NUM_BINS - (WINDOW_BEFORE % NUM_BINS)) % NUM_BINS;
   localparam int KEY_W  = hcpp_pkg::COUNT_W + BIN_W;
   localparam int PP_W   = BIN_W + hcpp_pkg::WIDTH_W;
   localparam int Q_W    = hcpp_pkg::PROD_W - hcpp_pkg::FRAC_W;

   // config
   logic signed [hcpp_pkg::SAMPLE_W-1:0] min_value_ff;
   logic [hcpp_pkg::SCALE_W-1:0]         bin_scale_ff;
   logic [hcpp_pkg::WIDTH_W-1:0]         bin_width_ff;
   logic [hcpp_pkg::LIMIT_W-1:0]         peak_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff  <= hcpp_pkg::MIN_VALUE_RST;
         bin_scale_ff  <= hcpp_pkg::BIN_SCALE_RST;
         bin_width_ff  <= hcpp_pkg::BIN_WIDTH_RST;
         peak_limit_ff <= hcpp_pkg::PEAK_LIMIT_RST;
      end else if (csr_we) begin
         case (hcpp_pkg::csr_index_type'(csr_index))
            hcpp_pkg::CSR_MIN_VALUE:  min_value_ff  <= csr_wdata[hcpp_pkg::SAMPLE_W-1:0];
            hcpp_pkg::CSR_BIN_SCALE:  bin_scale_ff  <= csr_wdata[hcpp_pkg::SCALE_W-1:0];
            hcpp_pkg::CSR_BIN_WIDTH:  bin_width_ff  <= csr_wdata[hcpp_pkg::WIDTH_W-1:0];
            hcpp_pkg::CSR_PEAK_LIMIT: peak_limit_ff <= csr_wdata[hcpp_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // binning
   logic signed [hcpp_pkg::DIFF_W-1:0] diff_ff;
   logic signed [hcpp_pkg::DIFF_W-1:0] diff_in;
   logic signed [hcpp_pkg::PROD_W-1:0] prod_ff;
   logic signed [hcpp_pkg::PROD_W-1:0] prod_in;
   logic signed [hcpp_pkg::SCALE_W:0]  scale_s;
   logic [Q_W-1:0]                     quot;
   logic [BIN_W-1:0]                   acc_bin;
   logic [BIN_W-1:0]                   upd_addr_ff;

   assign diff_in = hcpp_pkg::DIFF_W'(req_sample) - hcpp_pkg::DIFF_W'(min_value_ff);
   assign scale_s = $signed({1'b0, bin_scale_ff});
   assign prod_in = hcpp_pkg::PROD_W'(diff_ff) * hcpp_pkg::PROD_W'(scale_s)
                  + (hcpp_pkg::PROD_W'(1) <<< (hcpp_pkg::FRAC_W - 1));
   assign quot    = prod_ff[hcpp_pkg::PROD_W-1:hcpp_pkg::FRAC_W];

   always_comb begin
      if (prod_ff[hcpp_pkg::PROD_W-1] || (quot >= Q_W'(NUM_BINS - 1))) begin
         acc_bin = BIN_W'(NUM_BINS - 1);
      end else begin
         acc_bin = quot[BIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         diff_ff <= diff_in;
      end
      if (cmd.acc_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_rd) begin
         upd_addr_ff <= acc_bin;
      end
   end

   // address walk
   logic [BIN_W-1:0] addr_ff;
   logic [BIN_W-1:0] addr_next;
   logic [RD_W-1:0]  count_ff;

   assign addr_next = (addr_ff == BIN_W'(NUM_BINS - 1)) ? '0 : addr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_init) begin
         addr_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.scan_init) begin
         addr_ff  <= BIN_W'(START);
         count_ff <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
         addr_ff  <= addr_next;
         count_ff <= count_ff + 1'b1;
      end
   end

   // bin memory
   logic [hcpp_pkg::COUNT_W-1:0] mem [NUM_BINS];
   logic [hcpp_pkg::COUNT_W-1:0] rdata_ff;
   logic [BIN_W-1:0]             raddr;
   logic [BIN_W-1:0]             waddr;
   logic [hcpp_pkg::COUNT_W-1:0] wdata;
   logic                         we;

   always_comb begin
      raddr = cmd.acc_rd ? acc_bin : addr_ff;
      we    = cmd.acc_wr || cmd.clr_wr;
      waddr = cmd.acc_wr ? upd_addr_ff : addr_ff;
      if (cmd.acc_wr) begin
         wdata = (rdata_ff == '1) ? rdata_ff : rdata_ff + 1'b1;
      end else begin
         wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // suppression window
   logic                         rd_vld_ff;
   logic [BIN_W-1:0]             rd_idx_ff;
   logic                         win_new_ff;
   logic [FILL_W-1:0]            fill_ff;
   logic [hcpp_pkg::COUNT_W-1:0] win_cnt_ff [WIN];
   logic [BIN_W-1:0]             win_idx_ff [WIN];
   logic [KEY_W-1:0]             cand_key;
   logic                         survive;
   logic                         cand_vld_ff;
   logic [hcpp_pkg::COUNT_W-1:0] cand_cnt_ff;
   logic [BIN_W-1:0]             cand_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         win_new_ff  <= 1'b0;
         cand_vld_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         rd_vld_ff   <= cmd.scan_rd;
         win_new_ff  <= rd_vld_ff;
         cand_vld_ff <= win_new_ff && (fill_ff == FILL_W'(WIN)) && survive
                        && (cand_key != '0);
         if (cmd.scan_init) begin
            fill_ff <= '0;
         end else if (rd_vld_ff && (fill_ff != FILL_W'(WIN))) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (rd_vld_ff) begin
         for (int k = 0; k < WIN - 1; k++) begin
            win_cnt_ff[k] <= win_cnt_ff[k+1];
            win_idx_ff[k] <= win_idx_ff[k+1];
         end
         win_cnt_ff[WIN-1] <= rdata_ff;
         win_idx_ff[WIN-1] <= rd_idx_ff;
      end
      cand_cnt_ff <= win_cnt_ff[WINDOW_BEFORE];
      cand_idx_ff <= win_idx_ff[WINDOW_BEFORE];
   end

   assign cand_key = {win_cnt_ff[WINDOW_BEFORE], win_idx_ff[WINDOW_BEFORE]};

   always_comb begin
      survive = 1'b1;
      for (int k = 0; k < WIN; k++) begin
         if ({win_cnt_ff[k], win_idx_ff[k]} > cand_key) begin
            survive = 1'b0;
         end
      end
   end

   // ranked peak list
   logic [hcpp_pkg::COUNT_W-1:0] best_cnt_ff [MAX_PEAKS];
   logic [BIN_W-1:0]             best_idx_ff [MAX_PEAKS];
   logic [MAX_PEAKS-1:0]         best_vld_ff;
   logic [MAX_PEAKS:0]           vld_ext;
   logic [MAX_PEAKS-1:0]         gt;
   logic [MAX_PEAKS:0]           gt_prev;
   logic [hcpp_pkg::LIMIT_W-1:0] emit_cnt_ff;

   assign vld_ext = {1'b0, best_vld_ff};
   assign gt_prev = {gt, 1'b0};

   always_comb begin
      for (int p = 0; p < MAX_PEAKS; p++) begin
         gt[p] = !best_vld_ff[p]
               || ({cand_cnt_ff, cand_idx_ff} > {best_cnt_ff[p], best_idx_ff[p]});
      end
   end

   // valid entries stay packed from slot 0, so an insert grows the list by one
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_init) begin
         best_vld_ff <= '0;
         emit_cnt_ff <= '0;
      end else if (cmd.emit) begin
         best_vld_ff <= vld_ext[MAX_PEAKS:1];
         emit_cnt_ff <= emit_cnt_ff + 1'b1;
      end else if (cand_vld_ff) begin
         best_vld_ff <= (best_vld_ff << 1) | MAX_PEAKS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         for (int p = 0; p < MAX_PEAKS - 1; p++) begin
            best_cnt_ff[p] <= best_cnt_ff[p+1];
            best_idx_ff[p] <= best_idx_ff[p+1];
         end
      end else if (cand_vld_ff) begin
         if (gt[0]) begin
            best_cnt_ff[0] <= cand_cnt_ff;
            best_idx_ff[0] <= cand_idx_ff;
         end
         for (int p = 1; p < MAX_PEAKS; p++) begin
            if (gt[p] && gt_prev[p]) begin
               best_cnt_ff[p] <= best_cnt_ff[p-1];
               best_idx_ff[p] <= best_idx_ff[p-1];
            end else if (gt[p]) begin
               best_cnt_ff[p] <= cand_cnt_ff;
               best_idx_ff[p] <= cand_idx_ff;
            end
         end
      end
   end

   // result words
   logic [PP_W-1:0]                 pos_prod;
   logic [hcpp_pkg::POS_W-1:0]      pos_sum;
   logic [BIN_W+hcpp_pkg::BIN_OUT_W-1:0] idx_ext;
   logic                            is_last;
   logic                            rsp_valid_ff;
   logic [hcpp_pkg::BIN_OUT_W-1:0]  rsp_bin_index_ff;
   logic [hcpp_pkg::COUNT_W-1:0]    rsp_hit_count_ff;
   logic [hcpp_pkg::POS_W-1:0]      rsp_peak_position_ff;
   logic                            rsp_last_ff;

   assign pos_prod = PP_W'(best_idx_ff[0]) * PP_W'(bin_width_ff);
   assign pos_sum  = hcpp_pkg::POS_W'(min_value_ff) + hcpp_pkg::POS_W'(pos_prod);
   assign idx_ext  = {{hcpp_pkg::BIN_OUT_W{1'b0}}, best_idx_ff[0]};
   assign is_last  = (({1'b0, emit_cnt_ff} + 1'b1) == {1'b0, peak_limit_ff}) || !vld_ext[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_bin_index_ff     <= idx_ext[hcpp_pkg::BIN_OUT_W-1:0];
         rsp_hit_count_ff     <= best_cnt_ff[0];
         rsp_peak_position_ff <= pos_sum;
         rsp_last_ff          <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_index     = rsp_bin_index_ff;
   assign rsp_hit_count     = rsp_hit_count_ff;
   assign rsp_peak_position = $signed(rsp_peak_position_ff);
   assign rsp_last          = rsp_last_ff;

   assign status.clr_last  = (addr_ff == BIN_W'(NUM_BINS - 1));
   assign status.scan_last = (count_ff == RD_W'(READS - 1));
   assign status.pipe_busy = rd_vld_ff || win_new_ff || cand_vld_ff;
   assign status.emit_more = best_vld_ff[0] && (emit_cnt_ff < peak_limit_ff);

endmodule

>>> hw/rtl/histogram_circular_peak_picker.sv
// ----------------------------------------------------------------------------
// histogram_circular_peak_picker
// Bins angle samples into a saturating histogram; on finish runs circular
// non-maximum suppression and emits the strongest peaks, then clears.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   req_mode, req_sample                start & !busy
//  response  rsp_bin_index .. rsp_last           rsp_valid, one cycle, no stall
//  csr       csr_index, csr_wdata                csr_valid & csr_ready
//
//  Accumulate word: multiply, read, write-back of one bin.
//  Finish word: NUM_BINS + 2*WINDOW_BEFORE - 1 reads through the window, a
//  drain of the window pipeline, one peak per cycle, then a closing step and
//  a clear sweep over all NUM_BINS bins.
//  After reset the bin memory is cleared with busy high.
//  csr_ready is always high; responses cannot be held off.
// ----------------------------------------------------------------------------
module histogram_circular_peak_picker #(
   parameter int NUM_BINS      = 256,
   parameter int WINDOW_BEFORE = 3,
   parameter int MAX_PEAKS     = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic signed [hcpp_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   output logic [hcpp_pkg::BIN_OUT_W-1:0]       rsp_bin_index,
   output logic [hcpp_pkg::COUNT_W-1:0]         rsp_hit_count,
   output logic signed [hcpp_pkg::POS_W-1:0]    rsp_peak_position,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hcpp_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [hcpp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   hcpp_pkg::cmd_type    cmd;
   hcpp_pkg::status_type status;

   assign csr_ready = 1'b1;

   hcpp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   hcpp_datapath #(
      .NUM_BINS      (NUM_BINS),
      .WINDOW_BEFORE (WINDOW_BEFORE),
      .MAX_PEAKS     (MAX_PEAKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample        (req_sample),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_peak_position (rsp_peak_position),
      .rsp_last          (rsp_last)
   );

endmodule

>>> hw/rtl/hcpp_checker.sv
// ----------------------------------------------------------------------------
// hcpp_checker
// Port-level checks of the peak picker's command and response behavior.
// ----------------------------------------------------------------------------
module hcpp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last
);

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response word outside a busy period");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted word");

   a_peaks_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a peak burst");

   a_burst_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("response word after the last peak");

endmodule

bind histogram_circular_peak_picker hcpp_checker u_hcpp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

>>> dv/histogram_circular_peak_picker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_circular_peak_picker_tb
// Drives angle words and finish words into the peak picker and checks each
// emitted peak word against a cycle-free predictor of the histogram, the
// circular suppression window and the ranking. A directed table comes first,
// then randomized clustered sets under three sender idling profiles.
// ----------------------------------------------------------------------------
module histogram_circular_peak_picker_tb;

   localparam int NBINS         = 256;
   localparam int WIN_BEFORE    = 3;
   localparam int PEAKS_MAX     = 4;
   localparam int SETTLE_CYCLES = 600;
   localparam int TABLE_ROWS    = 37;

   typedef struct packed {
      logic [7:0]  bin;
      logic [15:0] count;
      logic [31:0] position;
      logic        last;
   } peak_word_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      hcpp_pkg::csr_index_type csr;
      hcpp_pkg::mode_type      mode;
      logic [23:0]             value;
      logic [16:0]             reps;
      logic                    typed;
      peak_word_type           want;
   } stim_row_type;

   localparam peak_word_type NO_PEAK = '0;

   // reset settings until the first register row; typed rows use them
   localparam stim_row_type DIR_TABLE [TABLE_ROWS] = '{
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b1,
        '{8'd255, 16'd0, 32'd12632, 1'b1}},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CDBC, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b1,
        '{8'd0, 16'd1, 32'hFFFFCDBC, 1'b1}},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h008000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h007FFF, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CE20, 17'd3, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CE84, 17'd2, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CEE8, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b0,
        NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_PEAK_LIMIT, hcpp_pkg::MODE_ACCUM, 24'd0, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CE20, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b0,
        NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_PEAK_LIMIT, hcpp_pkg::MODE_ACCUM, 24'd7, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CE20, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00CEE8, 17'd2, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b0,
        NO_PEAK},
      // half a bin rounds up
      '{ROW_CSR, hcpp_pkg::CSR_BIN_SCALE, hcpp_pkg::MODE_ACCUM, 24'h800000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h000000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_BIN_WIDTH, hcpp_pkg::MODE_ACCUM, 24'h00FFFF, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_PEAK_LIMIT, hcpp_pkg::MODE_ACCUM, 24'd2, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h000001, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h000000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h000003, 17'd2, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h00FFFF, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h00FFFF, 17'd1, 1'b0,
        NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h007FFF, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_BIN_SCALE, hcpp_pkg::MODE_ACCUM, 24'hFFFFFF, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_BIN_WIDTH, hcpp_pkg::MODE_ACCUM, 24'h000000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_PEAK_LIMIT, hcpp_pkg::MODE_ACCUM, 24'd5, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h008000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h007FFF, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b0,
        NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h008000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_BIN_SCALE, hcpp_pkg::MODE_ACCUM, 24'h000000, 17'd1, 1'b0, NO_PEAK},
      '{ROW_CSR, hcpp_pkg::CSR_PEAK_LIMIT, hcpp_pkg::MODE_ACCUM, 24'd1, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_ACCUM, 24'h005A5A, 17'd1, 1'b0, NO_PEAK},
      '{ROW_WORD, hcpp_pkg::CSR_MIN_VALUE, hcpp_pkg::MODE_FINISH, 24'h000000, 17'd1, 1'b0,
        NO_PEAK}
   };

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic                                 req_mode;
   logic signed [hcpp_pkg::SAMPLE_W-1:0] req_sample;
   logic                                 rsp_valid;
   logic [hcpp_pkg::BIN_OUT_W-1:0]       rsp_bin_index;
   logic [hcpp_pkg::COUNT_W-1:0]         rsp_hit_count;
   logic signed [hcpp_pkg::POS_W-1:0]    rsp_peak_position;
   logic                                 rsp_last;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [hcpp_pkg::CSR_ADDR_W-1:0]      csr_index;
   logic [hcpp_pkg::CSR_DATA_W-1:0]      csr_wdata;

   logic [15:0]        hist [NBINS];
   logic signed [15:0] cfg_min;
   logic [23:0]        cfg_scale;
   logic [15:0]        cfg_width;
   logic [2:0]         cfg_limit;
   peak_word_type      expected_peaks [$];
   int                 fail_count;
   int                 idle_pct;

   histogram_circular_peak_picker dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_peak_position (rsp_peak_position),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] bin_key(int b);
      return {hist[b], 16'(b)};
   endfunction

   function automatic void add_expected(peak_word_type w);
      expected_peaks.insert(expected_peaks.size(), w);
   endfunction

   function automatic int bin_of(logic [15:0] sample);
      longint num;
      longint q;
      num = (longint'($signed(sample)) - longint'(cfg_min)) * longint'(cfg_scale)
            + 64'sd8388608;
      if (num < 0) return NBINS - 1;
      q = num >>> 24;
      return (q < NBINS - 1) ? int'(q) : NBINS - 1;
   endfunction

   function automatic bit is_peak(int b);
      int e;
      for (int j = -WIN_BEFORE; j < WIN_BEFORE; j++) begin
         e = (b + j + 2 * NBINS) % NBINS;
         if (bin_key(e) > bin_key(b)) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic count_sample(logic [15:0] sample);
      int b;
      b = bin_of(sample);
      if (hist[b] != 16'hFFFF) hist[b] = hist[b] + 16'd1;
   endtask

   // non-maximum suppression, ranking, then the histogram clears
   task automatic pick_peaks(output peak_word_type found[$]);
      int            ranked [$];
      int            lim;
      int            n;
      int            p;
      longint        pos;
      peak_word_type w;
      found = {};
      for (int b = 0; b < NBINS; b++) begin
         if (bin_key(b) != 0 && is_peak(b)) begin
            p = 0;
            while (p < ranked.size() && bin_key(ranked[p]) > bin_key(b)) p++;
            if (p < PEAKS_MAX) begin
               ranked.insert(p, b);
               if (ranked.size() > PEAKS_MAX) void'(ranked.pop_back());
            end
         end
      end
      lim = (cfg_limit < PEAKS_MAX) ? int'(cfg_limit) : PEAKS_MAX;
      n = (ranked.size() < lim) ? ranked.size() : lim;
      for (int k = 0; k < n; k++) begin
         pos = longint'(cfg_min) + longint'(ranked[k]) * longint'(cfg_width);
         w.bin = 8'(ranked[k]);
         w.count = hist[ranked[k]];
         w.position = pos[31:0];
         w.last = (k == n - 1);
         found.insert(found.size(), w);
      end
      for (int b = 0; b < NBINS; b++) hist[b] = '0;
   endtask

   function automatic logic [15:0] angle_near(int center);
      int     b;
      longint off;
      if (cfg_scale == 0 || $urandom_range(0, 3) == 0) return 16'($urandom);
      b = center + int'($urandom_range(0, 2)) - 1;
      off = ((longint'(b) <<< 24) - 64'sd8388608
             + longint'($urandom_range(0, 24'hFFFFFF))) / longint'(cfg_scale);
      return 16'(longint'(cfg_min) + off);
   endfunction

   task automatic send_word(hcpp_pkg::mode_type mode, logic [15:0] sample, logic typed,
                            peak_word_type want);
      peak_word_type found [$];
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_sample <= sample;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (mode == hcpp_pkg::MODE_ACCUM) begin
         count_sample(sample);
      end else begin
         pick_peaks(found);
         if (typed) add_expected(want);
         else foreach (found[k]) add_expected(found[k]);
      end
      if ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   endtask

   task automatic stop_sender();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // a finish may still be sweeping with nothing left to emit
   task automatic settle();
      stop_sender();
      while (expected_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(hcpp_pkg::csr_index_type idx, logic [23:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         hcpp_pkg::CSR_MIN_VALUE:  cfg_min = data[15:0];
         hcpp_pkg::CSR_BIN_SCALE:  cfg_scale = data;
         hcpp_pkg::CSR_BIN_WIDTH:  cfg_width = data[15:0];
         hcpp_pkg::CSR_PEAK_LIMIT: cfg_limit = data[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // clustered sets so real peaks and ties form; some words are plain noise
   task automatic run_random(int words, int pct);
      int sent;
      int set_len;
      int centers [4];
      idle_pct = pct;
      for (int seg = 0; seg < 2; seg++) begin
         settle();
         write_reg(hcpp_pkg::CSR_MIN_VALUE, 24'($urandom_range(0, 16'hFFFF)));
         if ($urandom_range(0, 4) == 0)
            write_reg(hcpp_pkg::CSR_BIN_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
         else
            write_reg(hcpp_pkg::CSR_BIN_SCALE,
                      24'($urandom_range(24'h020000, 24'hFFFFFF)));
         write_reg(hcpp_pkg::CSR_BIN_WIDTH, 24'($urandom_range(0, 16'hFFFF)));
         if ($urandom_range(0, 4) == 0)
            write_reg(hcpp_pkg::CSR_PEAK_LIMIT, 24'($urandom_range(0, 7)));
         else
            write_reg(hcpp_pkg::CSR_PEAK_LIMIT, 24'($urandom_range(1, 4)));
         sent = 0;
         while (sent < words / 2) begin
            set_len = $urandom_range(0, 20);
            foreach (centers[c]) centers[c] = $urandom_range(0, NBINS - 1);
            for (int k = 0; k < set_len; k++)
               send_word(hcpp_pkg::MODE_ACCUM,
                         angle_near(centers[$urandom_range(0, 3)]), 1'b0, NO_PEAK);
            send_word(hcpp_pkg::MODE_FINISH, 16'($urandom), 1'b0, NO_PEAK);
            sent += set_len + 1;
         end
      end
   endtask

   always @(posedge clock) begin : check_peaks
      peak_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_peaks.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected peak word: bin %0d count %0d position %0d last %0d",
                        rsp_bin_index, rsp_hit_count, rsp_peak_position, rsp_last);
            fail_count++;
         end else begin
            want = expected_peaks.pop_front();
            if (rsp_bin_index !== want.bin || rsp_hit_count !== want.count ||
                rsp_peak_position !== want.position || rsp_last !== want.last) begin
               if (fail_count < 10) begin
                  $write("peak word mismatch: expected bin %0d count %0d pos %0d last %0d,",
                         want.bin, want.count, $signed(want.position), want.last);
                  $display(" got bin %0d count %0d pos %0d last %0d",
                           rsp_bin_index, rsp_hit_count, rsp_peak_position, rsp_last);
               end
               fail_count++;
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = hcpp_pkg::MODE_ACCUM;
      req_sample = '0;
      csr_valid = 1'b0;
      csr_index = hcpp_pkg::CSR_MIN_VALUE;
      csr_wdata = '0;
      fail_count = 0;
      idle_pct = 36;
      cfg_min = hcpp_pkg::MIN_VALUE_RST;
      cfg_scale = hcpp_pkg::BIN_SCALE_RST;
      cfg_width = hcpp_pkg::BIN_WIDTH_RST;
      cfg_limit = hcpp_pkg::PEAK_LIMIT_RST;
      for (int b = 0; b < NBINS; b++) hist[b] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      foreach (DIR_TABLE[r]) begin
         if (DIR_TABLE[r].kind == ROW_CSR) begin
            settle();
            write_reg(DIR_TABLE[r].csr, DIR_TABLE[r].value);
         end else begin
            repeat (DIR_TABLE[r].reps)
               send_word(DIR_TABLE[r].mode, DIR_TABLE[r].value[15:0],
                         DIR_TABLE[r].typed, DIR_TABLE[r].want);
         end
      end

      run_random(72, 36);
      run_random(72, 57);
      run_random(72, 0);

      stop_sender();
      while (expected_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
